// ===== rtl/skvt_pkg.sv =====
// types and constants shared by the sorted key/value table
// no dependencies
package skvt_pkg;

  typedef logic signed [31:0] skvt_word_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } skvt_func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } skvt_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_UPD  = 1'b1
  } skvt_state_t;

  typedef struct packed {
    skvt_func_t func;
    skvt_word_t key;
    skvt_word_t value;
  } skvt_req_t;

  typedef struct packed {
    skvt_status_t status;
    skvt_word_t   removed_key;
    skvt_word_t   removed_value;
  } skvt_rsp_t;

  typedef struct packed {
    skvt_word_t key;
    skvt_word_t value;
  } skvt_entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } skvt_ctrl_t;

endpackage

// ===== rtl/skvt_cell.sv =====
// one slot of the sorted table: holds an entry, compares it to the search key
// and shifts toward either neighbor; depends on skvt_pkg
module skvt_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 5
) (
  input  logic                 clk,
  input  logic                 load,
  input  skvt_pkg::skvt_word_t cmp_key,
  input  logic [CNT_W-1:0]     cnt,
  input  skvt_pkg::skvt_ctrl_t ctrl,
  input  skvt_pkg::skvt_entry_t new_ent,
  input  skvt_pkg::skvt_entry_t lo_ent,
  input  logic                 lo_lt,
  input  skvt_pkg::skvt_entry_t hi_ent,
  output skvt_pkg::skvt_entry_t ent,
  output logic                 lt,
  output logic                 eq,
  output skvt_pkg::skvt_word_t sel_key,
  output skvt_pkg::skvt_word_t sel_value
);
  import skvt_pkg::*;

  logic in_use;

  assign in_use = CNT_W'(CELL_IDX) < cnt;

  // lt: slot holds a larger key or is empty
  always_ff @(posedge clk) begin
    if (load) begin
      lt <= !in_use || (cmp_key < ent.key);
      eq <= in_use && (cmp_key == ent.key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && lt) begin
      ent <= lo_lt ? lo_ent : new_ent;
    end else if (ctrl.rem && (lt || eq)) begin
      ent <= hi_ent;
    end
  end

  assign sel_key   = eq ? ent.key   : '0;
  assign sel_value = eq ? ent.value : '0;

endmodule

// ===== rtl/sorted_key_value_table_unit.sv =====
// sorted key/value table: a chain of compare-and-shift cells
// depends on skvt_pkg and skvt_cell
//
//   port       dir   word         role
//   req        in    skvt_req_t   insert pair or remove by key
//   rsp        out   skvt_rsp_t   status and removed pair
//
// a request is latched along with the per-cell compare flags when it is taken,
// then the update state shifts the cells and loads the response register
// a new request is taken only while no request is being worked on
// the update cycle waits while the response register is full and stalled
// reset empties the table; entry contents are not cleared
module sorted_key_value_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  skvt_pkg::skvt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output skvt_pkg::skvt_rsp_t rsp
);
  import skvt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  skvt_state_t      state, state_next;
  logic [CNT_W-1:0] count;
  skvt_req_t        op;
  skvt_ctrl_t       ctrl;
  logic             load, go, hit, full;
  skvt_status_t     status_next;

  skvt_entry_t       ents [CAPACITY];
  skvt_word_t        sel_keys [CAPACITY];
  skvt_word_t        sel_values [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, eq_vec;
  skvt_entry_t       new_ent;
  skvt_word_t        rk_acc, rv_acc;

  assign load    = req_valid && !req_stall;
  assign new_ent = '{key: op.key, value: op.value};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skvt_cell #(
      .CELL_IDX(i),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk      (clk),
      .load     (load),
      .cmp_key  (req.key),
      .cnt      (count),
      .ctrl     (ctrl),
      .new_ent  (new_ent),
      .lo_ent   ((i == 0) ? ents[0] : ents[(i == 0) ? 0 : i - 1]),
      .lo_lt    ((i == 0) ? 1'b0 : lt_vec[(i == 0) ? 0 : i - 1]),
      .hi_ent   ((i == CAPACITY - 1) ? ents[i] : ents[(i == CAPACITY - 1) ? i : i + 1]),
      .ent      (ents[i]),
      .lt       (lt_vec[i]),
      .eq       (eq_vec[i]),
      .sel_key  (sel_keys[i]),
      .sel_value(sel_values[i])
    );
  end

  assign hit  = |eq_vec;
  assign full = count == CNT_W'(CAPACITY);

  always_comb begin
    rk_acc = '0;
    rv_acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rk_acc = rk_acc | sel_keys[i];
      rv_acc = rv_acc | sel_values[i];
    end
  end

  always_comb begin
    priority if (op.func == FUNC_INSERT) begin
      priority if (hit) status_next = ST_DUPLICATE;
      else if (full) status_next = ST_FULL;
      else status_next = ST_OK;
    end else begin
      status_next = hit ? ST_OK : ST_NOT_FOUND;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (load) state_next = S_UPD;
      S_UPD:  if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    go        = 1'b0;
    unique case (state)
      S_IDLE: req_stall = 1'b0;
      S_UPD:  go = !rsp_valid || !rsp_stall;
      default: req_stall = 1'b1;
    endcase
    ctrl.ins = go && (op.func == FUNC_INSERT) && !hit && !full;
    ctrl.rem = go && (op.func == FUNC_REMOVE) && hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.ins) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.rem) begin
        count <= count - CNT_W'(1);
      end
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op <= req;
    end
    if (go) begin
      rsp.status        <= status_next;
      rsp.removed_key   <= ctrl.rem ? rk_acc : '0;
      rsp.removed_value <= ctrl.rem ? rv_acc : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_ctrl_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove at once");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_UPD))
    else $error("response word without an update cycle");

endmodule
